[rtl/core/mesi_pkg.sv]
package mesi_pkg;
  localparam int SOCKETS = 8;
  localparam int ENTRIES = 1024;
  localparam int SW = 3;   // socket index bits
  localparam int TW = 4;   // target width (holds SOCKETS)
  localparam int IW = 10;  // line index bits
  localparam int CW = 4;   // sharer count bits

  localparam logic [1:0] ST_I = 2'd0;
  localparam logic [1:0] ST_S = 2'd1;
  localparam logic [1:0] ST_E = 2'd2;
  localparam logic [1:0] ST_M = 2'd3;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_INV   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  localparam logic [TW-1:0] NONE = TW'(SOCKETS);

  typedef struct packed {
    logic [1:0]         st;
    logic [TW-1:0]      ow;
    logic [SOCKETS-1:0] sh;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, issue memory read
    logic eval;      // compute new entry from read data
    logic lfsr_step; // advance LFSR one step
    logic pick_step; // scan one sharer for hand-off / selection
    logic inv_step;  // advance invalidate scan
    logic commit;    // write entry back
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clearing;    // memory clearing pass after reset
    logic func;
    logic need_rand;   // write in S by owner with other sharers
    logic cand_set;    // hand-off candidate already chosen
    logic pick_more;   // hand-off scan not finished
    logic inv_pending; // invalidates still to send
  } stat_t;
endpackage

[rtl/core/mesi_dp.sv]
module mesi_dp import mesi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic [14:0]       in_word,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic [1:0]        o_kind,
  output logic [TW-1:0]     o_target,
  output logic              o_error
);
  // directory memory; a pass after reset writes every line to invalid, one a cycle
  entry_t mem [ENTRIES];
  entry_t rd;

  logic          func, wr;
  logic [IW-1:0] idx;
  logic [SW-1:0] s;
  logic [15:0]   lfsr;

  entry_t cur;
  logic [SOCKETS-1:0] inv_mask, scan, others;
  logic [TW-1:0] reply, cand, ow_new;
  logic [CW-1:0] kcnt, ccnt;
  logic [1:0]    st_new;
  logic          err;
  logic [SOCKETS-1:0] sh_new;
  logic [SOCKETS-1:0] ent_others, ent_rest;

  logic [15:0] lfsr_nx;
  assign lfsr_nx = lfsr[0] ? ((lfsr >> 1) ^ 16'hB400) : (lfsr >> 1);

  logic [IW:0] clr;
  logic clearing;
  assign clearing = !clr[IW];

  always_ff @(posedge clk) begin
    if (rst) clr <= '0;
    else if (clearing) clr <= clr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (clearing) mem[clr[IW-1:0]] <= '{ST_I, NONE, '0};
    else if (cmd.commit) mem[idx] <= '{st_new, ow_new, sh_new};
    if (cmd.load) rd <= mem[in_word[10:1]];
  end

  always_ff @(posedge clk) begin
    if (rst) lfsr <= 16'd1;
    else if (cfg_we) lfsr <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
    else if (cmd.lfsr_step) lfsr <= lfsr_nx;
  end

  function automatic logic [CW-1:0] popc(input logic [SOCKETS-1:0] m);
    logic [CW-1:0] c;
    c = '0;
    for (int i = 0; i < SOCKETS; i++) c = c + CW'(m[i]);
    return c;
  endfunction

  function automatic logic [TW-1:0] lowest(input logic [SOCKETS-1:0] m);
    logic [TW-1:0] r;
    r = NONE;
    for (int i = SOCKETS - 1; i >= 0; i--) if (m[i]) r = TW'(i);
    return r;
  endfunction

  // LFSR value mod count, count 1..7. 4, 16 and 8 are 1 modulo 3, 5 and 7,
  // so digit sums fold the value down; mod 6 combines mod 3 with the low bit.
  function automatic logic [CW-1:0] modc(input logic [15:0] v, input logic [CW-1:0] c);
    logic [4:0] s3;
    logic [2:0] a3, r3;
    logic [5:0] s5;
    logic [4:0] a5, r5;
    logic [5:0] s7;
    logic [3:0] a7, r7;
    logic [CW-1:0] r;
    s3 = '0;
    for (int i = 0; i < 8; i++) s3 = s3 + 5'(v[2*i +: 2]);
    a3 = 3'(s3[1:0]) + 3'(s3[3:2]) + 3'(s3[4]);
    r3 = 3'(a3[1:0]) + 3'(a3[2]);
    if (r3 >= 3'd3) r3 = r3 - 3'd3;
    s5 = '0;
    for (int i = 0; i < 4; i++) s5 = s5 + 6'(v[4*i +: 4]);
    a5 = 5'(s5[3:0]) + 5'(s5[5:4]);
    r5 = 5'(a5[3:0]) + 5'(a5[4]);
    if (r5 >= 5'd10) r5 = r5 - 5'd10;
    if (r5 >= 5'd5) r5 = r5 - 5'd5;
    s7 = 6'(v[15]);
    for (int i = 0; i < 5; i++) s7 = s7 + 6'(v[3*i +: 3]);
    a7 = 4'(s7[2:0]) + 4'(s7[5:3]);
    r7 = 4'(a7[2:0]) + 4'(a7[3]);
    if (r7 >= 4'd7) r7 = r7 - 4'd7;
    unique case (c)
      CW'(2): r = CW'(v[0]);
      CW'(3): r = CW'(r3);
      CW'(4): r = CW'(v[1:0]);
      CW'(5): r = CW'(r5);
      CW'(6): r = CW'(r3) + ((r3[0] ^ v[0]) ? CW'(3) : CW'(0));
      CW'(7): r = CW'(r7);
      default: r = '0;
    endcase
    return r;
  endfunction

  entry_t ent;
  assign ent = rd;

  // sharers other than the requester; an eviction with its bit clear drops all
  assign ent_others = ent.sh & ~(SOCKETS'(1) << s);
  assign ent_rest   = (func && !ent.sh[s]) ? '0 : ent_others;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= in_word[0];
      idx  <= in_word[10:1];
      s    <= in_word[13:11];
      wr   <= in_word[14];
      inv_mask <= '0;
      err <= 1'b0;
    end else if (cmd.eval) begin
      cur      <= '{ent.st, ent.ow, ent_rest};
      err      <= func && !ent.sh[s];
      scan     <= func ? ent_rest : '0;
      inv_mask <= func ? {SOCKETS{!ent.sh[s]}} : (wr ? ent_others : '0);
      others   <= ent_others;
      ccnt     <= popc(ent_others);
      cand     <= NONE;
      if (!func && (ent.st == ST_E || ent.st == ST_M) && !ent.sh[s] && ent.ow < NONE)
        reply <= ent.ow;
      else if (!func && ent.st == ST_S && wr)
        reply <= (ent.ow < NONE) ? ent.ow : NONE;
      else
        reply <= NONE;
    end else if (cmd.lfsr_step && !func) begin
      // selection among others by LFSR value mod count
      kcnt <= modc(lfsr_nx, ccnt);
      scan <= others;
    end else if (cmd.pick_step) begin
      if (!func) begin
        if (kcnt == '0) begin
          reply <= lowest(scan);
          scan <= '0;
        end else begin
          kcnt <= kcnt - 1'b1;
          scan <= scan & (scan - 1'b1);
        end
      end else begin
        if (cand == NONE) cand <= lowest(scan);
        else if (!lfsr_nx[0]) cand <= lowest(scan);
        scan <= scan & (scan - 1'b1);
      end
    end else if (cmd.inv_step) begin
      inv_mask <= inv_mask & (inv_mask - 1'b1);
    end
  end

  // after eviction, remaining sharers = cur.sh
  always_comb begin
    st_new = cur.st;
    ow_new = cur.ow;
    sh_new = cur.sh;
    if (!func) begin
      sh_new = cur.sh | (SOCKETS'(1) << s);
      if (wr) begin
        sh_new = SOCKETS'(1) << s;
        st_new = ST_M;
        ow_new = TW'(s);
      end else if (popc(cur.sh | (SOCKETS'(1) << s)) > CW'(1)) st_new = ST_S;
      else if (cur.st != ST_M) begin
        st_new = ST_E;
        ow_new = TW'(s);
      end
    end else begin
      if (cur.st == ST_S) begin
        if (cur.ow == TW'(s)) ow_new = cand;
        if (popc(cur.sh) == CW'(1)) st_new = ST_E;
      end else if (cur.st == ST_E || cur.st == ST_M) begin
        st_new = ST_I;
        ow_new = NONE;
      end
    end
  end

  assign stat.clearing    = clearing;
  assign stat.func        = func;
  assign stat.need_rand   = !func && wr && cur.st == ST_S && cur.ow == TW'(s) && ccnt != '0;
  assign stat.cand_set    = cand != NONE;
  assign stat.pick_more   = scan != '0;
  assign stat.inv_pending = inv_mask != '0;

  always_comb begin
    o_error = 1'b0;
    if (inv_mask != '0) begin
      o_kind = KIND_INV;
      o_target = lowest(inv_mask);
    end else if (func) begin
      o_kind = KIND_DONE;
      o_target = NONE;
      o_error = err;
    end else begin
      o_kind = KIND_REPLY;
      o_target = reply;
    end
  end
endmodule

[rtl/core/mesi_ctrl.sv]
module mesi_ctrl import mesi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output logic  out_last,
  input  stat_t stat,
  output cmd_t  cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_RAND = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready  = state == S_IDLE && !stat.clearing;
  assign out_valid = state == S_OUT;
  assign out_last  = !stat.inv_pending;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: state_next = S_EVAL;
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = S_RAND;
      end
      S_RAND: begin
        if (stat.need_rand) begin
          cmd.lfsr_step = 1'b1;
          state_next = S_PICK;
        end else if (stat.func) state_next = S_PICK;
        else state_next = S_OUT;
      end
      S_PICK: begin
        if (stat.pick_more) begin
          cmd.pick_step = 1'b1;
          // every sharer after the first candidate costs one LFSR step
          cmd.lfsr_step = stat.func && stat.cand_set;
        end else state_next = S_OUT;
      end
      S_OUT: if (out_ready) begin
        if (stat.inv_pending) cmd.inv_step = 1'b1;
        else begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

[rtl/core/mesi_socket_coherence_directory.sv]
// MESI directory, 1024 lines x 8 sockets. One request at a time: accept, entry
// read, evaluate and random-step decision follow in turn; an eviction then scans
// its remaining sharers one a cycle, and an owner write in S scans up to the
// chosen sharer's rank; then results go out one word per cycle while m_tready is
// high (invalidates in rising socket order, then the reply or eviction-done word
// with tlast). After reset a pass clears every line of the directory memory
// before s_tready rises.
module mesi_socket_coherence_directory import mesi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // func, line_index[9:0], socket[2:0], is_write
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [7:0]  m_tdata,  // kind[1:0], target_socket[3:0], error
  output logic        m_tlast
);
  cmd_t  cmd;
  stat_t stat;
  logic [1:0] kind;
  logic [TW-1:0] tgt;
  logic err;

  mesi_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_last(m_tlast),
    .stat, .cmd
  );

  mesi_dp u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .in_word(s_tdata[14:0]), .cmd, .stat,
    .o_kind(kind), .o_target(tgt), .o_error(err)
  );

  assign m_tdata = {1'b0, err, tgt, kind};
endmodule

[rtl/core/mesi_checker.sv]
module mesi_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [7:0] m_tdata,
  input logic m_tlast
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken during output");
  a_inv_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == 2'd1 |-> !m_tlast) else $error("invalidate marked last");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output dropped");
endmodule

bind mesi_socket_coherence_directory mesi_checker u_chk (.*);
